/* design/tbrc_pkg.sv */
// shared codes and lane status type for the target byte read cache
package tbrc_pkg;

	localparam logic [1:0] FUNC_READ       = 2'd0;
	localparam logic [1:0] FUNC_WRITE      = 2'd1;
	localparam logic [1:0] FUNC_INVALIDATE = 2'd2;
	localparam logic [1:0] FUNC_ENABLE     = 2'd3;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_WORD = 2'd1;

	// last byte offset within an access
	localparam logic [1:0] LAST_BYTE = 2'd0;
	localparam logic [1:0] LAST_WORD = 2'd1;
	localparam logic [1:0] LAST_LONG = 2'd3;

	typedef struct packed {
		logic       match;
		logic [7:0] data;
	} lane_hit_t;

endpackage

/* design/tbrc_lane.sv */
// one cache slot: stored address, byte and valid mark, with its tag comparator
module tbrc_lane #(
	parameter int ADDR_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [7:0]           wr_byte,
	input  logic [ADDR_BITS-1:0] cmp_addr,
	output tbrc_pkg::lane_hit_t  status
);

	logic                 valid_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [7:0]           byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_q <= wr_addr;
			byte_q <= wr_byte;
		end
	end

	assign status.match = valid_q && (addr_q == cmp_addr);
	assign status.data  = byte_q;

endmodule

/* design/tbrc_merge.sv */
// merges lane compare results into found flag, slot index and byte
module tbrc_merge #(
	parameter int ENTRIES = 16
) (
	input  tbrc_pkg::lane_hit_t          lanes [ENTRIES],
	output logic                         found,
	output logic [$clog2(ENTRIES)-1:0]   slot,
	output logic [7:0]                   data
);

	localparam int IDX_W = $clog2(ENTRIES);

	// at most one lane matches, so a plain or-merge is enough
	always_comb begin
		found = 1'b0;
		slot  = '0;
		data  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (lanes[i].match) begin
				found = 1'b1;
				slot  = slot | IDX_W'(i);
				data  = data | lanes[i].data;
			end
		end
	end

endmodule

/* design/target_byte_read_cache_top.sv */
// top level of the target byte read cache: sequencer, slot lanes and result register
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall  | func access_size address write_data target_data
//  out     | output    | out_valid/out_stall| read_data hit target_access
//
// one word is worked on at a time; the slot lookup steps through the bytes of the
// access one after another, all lanes compare in parallel against that byte's address.
// a read looks its bytes up in order and on a miss stores every byte from the first;
// a write updates its bytes; invalidate and enable go straight to the result.
// reset clears all valid marks, the replace pointer and the enable; slots are unknown.
// a finished result waits in the output register; the next word is taken meanwhile.
module target_byte_read_cache_top #(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [1:0]  access_size,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	input  logic [31:0] target_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        hit,
	output logic        target_access
);

	localparam int IDX_W = $clog2(ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_STORE,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [31:0]          data_q;
	logic [31:0]          acc_q;
	logic [1:0]           k_q;
	logic [1:0]           last_q;
	logic                 alloc_all_q;
	logic [IDX_W-1:0]     ptr_q;
	logic                 cache_on_q;
	logic [31:0]          res_data_q;
	logic                 res_hit_q;
	logic                 res_tacc_q;
	logic                 out_valid_q;
	logic [31:0]          read_data_q;
	logic                 hit_q;
	logic                 target_access_q;

	logic                 in_accept;
	logic [ADDR_BITS-1:0] cur_addr;
	logic [1:0]           sel;
	logic [7:0]           cur_byte;
	tbrc_pkg::lane_hit_t  lanes [ENTRIES];
	logic                 m_found;
	logic [IDX_W-1:0]     m_slot;
	logic [7:0]           m_data;
	logic                 found;
	logic                 store_en;
	logic [IDX_W-1:0]     wr_slot;
	logic                 clear_all;
	logic [31:0]          masked_tdata;
	logic [31:0]          next_acc;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign cur_addr = base_q + ADDR_BITS'(k_q);
	assign sel      = last_q - k_q;
	assign cur_byte = data_q[{sel, 3'b000} +: 8];

	assign found    = cache_on_q && m_found;
	assign store_en = (state_q == ST_STORE) && cache_on_q && (alloc_all_q || found);
	assign wr_slot  = found ? m_slot : ptr_q;
	assign next_acc = {acc_q[23:0], m_data};

	assign clear_all = in_accept && (func == tbrc_pkg::FUNC_INVALIDATE);

	always_comb begin
		case (access_size)
			tbrc_pkg::SIZE_BYTE: masked_tdata = {24'b0, target_data[7:0]};
			tbrc_pkg::SIZE_WORD: masked_tdata = {16'b0, target_data[15:0]};
			default:             masked_tdata = target_data;
		endcase
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_lane
		tbrc_lane #(
			.ADDR_BITS(ADDR_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.clear   (clear_all),
			.wr_en   (store_en && (wr_slot == IDX_W'(i))),
			.wr_addr (cur_addr),
			.wr_byte (cur_byte),
			.cmp_addr(cur_addr),
			.status  (lanes[i])
		);
	end

	tbrc_merge #(
		.ENTRIES(ENTRIES)
	) u_merge (
		.lanes(lanes),
		.found(m_found),
		.slot (m_slot),
		.data (m_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			base_q          <= '0;
			data_q          <= '0;
			acc_q           <= '0;
			k_q             <= '0;
			last_q          <= '0;
			alloc_all_q     <= 1'b0;
			ptr_q           <= '0;
			cache_on_q      <= 1'b0;
			res_data_q      <= '0;
			res_hit_q       <= 1'b0;
			res_tacc_q      <= 1'b0;
			out_valid_q     <= 1'b0;
			read_data_q     <= '0;
			hit_q           <= 1'b0;
			target_access_q <= 1'b0;
		end else begin
			// in the done state the output register is reloaded below instead
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						base_q     <= address[ADDR_BITS-1:0];
						k_q        <= '0;
						acc_q      <= '0;
						res_data_q <= '0;
						res_hit_q  <= 1'b0;
						res_tacc_q <= 1'b0;
						case (access_size)
							tbrc_pkg::SIZE_BYTE: last_q <= tbrc_pkg::LAST_BYTE;
							tbrc_pkg::SIZE_WORD: last_q <= tbrc_pkg::LAST_WORD;
							default:             last_q <= tbrc_pkg::LAST_LONG;
						endcase
						case (func)
							tbrc_pkg::FUNC_READ: begin
								data_q  <= masked_tdata;
								state_q <= ST_LOOK;
							end
							tbrc_pkg::FUNC_WRITE: begin
								data_q      <= write_data;
								alloc_all_q <= !(access_size == tbrc_pkg::SIZE_BYTE ||
								                 access_size == tbrc_pkg::SIZE_WORD);
								res_tacc_q  <= 1'b1;
								state_q     <= ST_STORE;
							end
							tbrc_pkg::FUNC_INVALIDATE: begin
								cache_on_q <= 1'b0;
								state_q    <= ST_DONE;
							end
							default: begin
								cache_on_q <= 1'b1;
								state_q    <= ST_DONE;
							end
						endcase
					end
				end
				ST_LOOK: begin
					if (found) begin
						acc_q <= next_acc;
						if (k_q == last_q) begin
							res_data_q <= next_acc;
							res_hit_q  <= 1'b1;
							state_q    <= ST_DONE;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end else begin
						// miss: return target data and, if the cache is on, fill every byte from the first
						res_data_q  <= data_q;
						res_tacc_q  <= 1'b1;
						alloc_all_q <= 1'b1;
						k_q         <= '0;
						state_q     <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (store_en && !found) begin
						ptr_q <= (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + IDX_W'(1);
					end
					if (k_q == last_q) begin
						state_q <= ST_DONE;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						read_data_q     <= res_data_q;
						hit_q           <= res_hit_q;
						target_access_q <= res_tacc_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign hit           = hit_q;
	assign target_access = target_access_q;

endmodule

/* sim/tb_target_byte_read_cache_top.sv */
// self-checking testbench for the target byte read cache, with a built-in cache predictor
module tb_target_byte_read_cache_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] SIZE_LONG  = 2'd2;
	localparam logic [1:0] SIZE_SPARE = 2'd3;
	localparam int SLOTS            = 16;
	localparam int RANDOM_PER_PHASE = 660;
	localparam int REGION_SPAN      = 23;
	localparam int HOLD_OFF_CYCLES  = 120;
	localparam int DRAIN_CYCLES     = 20;
	localparam int WATCHDOG_LIMIT   = 3000;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  size;
		logic [31:0] addr;
		logic [31:0] wdata;
		logic [31:0] tdata;
	} access_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic        hit;
		logic        tacc;
	} reply_t;

	typedef struct {
		access_t acc;
		bit      typed;
		reply_t  want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [1:0]  access_size = '0;
	logic [31:0] address = '0;
	logic [31:0] write_data = '0;
	logic [31:0] target_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic        hit;
	logic        target_access;

	target_byte_read_cache_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.access_size   (access_size),
		.address       (address),
		.write_data    (write_data),
		.target_data   (target_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.hit           (hit),
		.target_access (target_access)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted cache contents
	logic [31:0] slot_addr [SLOTS];
	logic [7:0]  slot_byte [SLOTS];
	logic        slot_valid [SLOTS];
	logic [3:0]  fill_ptr;
	logic        cache_en;

	reply_t   pending_results [$];
	dir_row_t dir_rows [$];
	int       send_idle_pct;
	int       recv_idle_pct;
	bit       hold_off_req = 1'b0;
	logic [31:0] region_base;
	int mismatch_count = 0;
	int n_read_hit = 0;
	int n_read_miss = 0;
	int n_write = 0;
	int n_control = 0;

	function automatic int lookup_slot(logic [31:0] a);
		if (!cache_en)
			return -1;
		for (int i = 0; i < SLOTS; i++)
			if (slot_valid[i] && slot_addr[i] == a)
				return i;
		return -1;
	endfunction

	function automatic void fill_byte(logic [31:0] a, logic [7:0] d);
		int s;
		if (!cache_en)
			return;
		s = lookup_slot(a);
		if (s < 0) begin
			s = fill_ptr;
			fill_ptr = fill_ptr + 4'd1;
		end
		slot_byte[s] = d;
		slot_addr[s] = a;
		slot_valid[s] = 1'b1;
	endfunction

	function automatic reply_t predict_access(access_t acc);
		reply_t r;
		int nbytes;
		int s;
		bit all_cached;
		logic [31:0] gathered;
		logic [31:0] td;
		r = '0;
		nbytes = (acc.size == tbrc_pkg::SIZE_BYTE) ? 1 :
			(acc.size == tbrc_pkg::SIZE_WORD) ? 2 : 4;
		case (acc.func)
			tbrc_pkg::FUNC_READ: begin
				all_cached = 1'b1;
				gathered = '0;
				for (int k = 0; k < nbytes; k++) begin
					s = lookup_slot(acc.addr + k);
					if (s < 0) begin
						all_cached = 1'b0;
						break;
					end
					gathered = {gathered[23:0], slot_byte[s]};
				end
				if (all_cached) begin
					r.rdata = gathered;
					r.hit = 1'b1;
				end else begin
					td = acc.tdata;
					if (nbytes < 4)
						td = td & ((32'd1 << (8 * nbytes)) - 32'd1);
					r.rdata = td;
					r.tacc = 1'b1;
					// bytes go in one after another, an early one may evict a later one
					for (int k = 0; k < nbytes; k++)
						fill_byte(acc.addr + k, 8'(td >> (8 * (nbytes - 1 - k))));
				end
			end
			tbrc_pkg::FUNC_WRITE: begin
				r.tacc = 1'b1;
				for (int k = 0; k < nbytes; k++)
					if (nbytes == 4 || lookup_slot(acc.addr + k) >= 0)
						fill_byte(acc.addr + k, 8'(acc.wdata >> (8 * (nbytes - 1 - k))));
			end
			tbrc_pkg::FUNC_INVALIDATE: begin
				for (int i = 0; i < SLOTS; i++)
					slot_valid[i] = 1'b0;
				cache_en = 1'b0;
			end
			default: cache_en = 1'b1;
		endcase
		return r;
	endfunction

	function automatic access_t random_access();
		access_t acc;
		int pick;
		pick = $urandom_range(99);
		acc.func = (pick < 55) ? tbrc_pkg::FUNC_READ : (pick < 90) ? tbrc_pkg::FUNC_WRITE :
			(pick < 92) ? tbrc_pkg::FUNC_INVALIDATE : tbrc_pkg::FUNC_ENABLE;
		acc.size = 2'($urandom_range(3));
		acc.addr = ($urandom_range(99) < 85) ? region_base + $urandom_range(REGION_SPAN) :
			$urandom;
		acc.wdata = $urandom;
		acc.tdata = $urandom;
		return acc;
	endfunction

	task automatic add_row(logic [1:0] f, logic [1:0] s, logic [31:0] a, logic [31:0] wd,
			logic [31:0] td, bit typed, logic [31:0] rd, logic h, logic ta);
		dir_row_t row;
		row.acc = '{func: f, size: s, addr: a, wdata: wd, tdata: td};
		row.typed = typed;
		row.want = '{rdata: rd, hit: h, tacc: ta};
		dir_rows.push_back(row);
	endtask

	// offer one word and book its expected result once it is taken
	task automatic send_access(access_t acc, bit typed, reply_t want);
		reply_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= acc.func;
		access_size <= acc.size;
		address <= acc.addr;
		write_data <= acc.wdata;
		target_data <= acc.tdata;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = predict_access(acc);
		pending_results.push_back(typed ? want : predicted);
		if (acc.func == tbrc_pkg::FUNC_READ) begin
			if (predicted.hit)
				n_read_hit++;
			else
				n_read_miss++;
		end else if (acc.func == tbrc_pkg::FUNC_WRITE)
			n_write++;
		else
			n_control++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, read_data %h hit %b target_access %b",
					$time, read_data, hit, target_access);
				mismatch_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (read_data !== exp_r.rdata) begin
					$display("%0t: read_data expected %h, got %h", $time, exp_r.rdata, read_data);
					mismatch_count++;
				end
				if (hit !== exp_r.hit) begin
					$display("%0t: hit expected %b, got %b", $time, exp_r.hit, hit);
					mismatch_count++;
				end
				if (target_access !== exp_r.tacc) begin
					$display("%0t: target_access expected %b, got %b", $time, exp_r.tacc,
						target_access);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++)
			slot_valid[i] = 1'b0;
		fill_ptr = '0;
		cache_en = 1'b0;
		region_base = 32'h0000_0400;
		send_idle_pct = 33;
		recv_idle_pct = 46;

		// disabled after reset: reads miss, nothing is filled
		add_row(tbrc_pkg::FUNC_READ, tbrc_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0,
			32'hAABB_CCDD, 1, 32'h0000_00DD, 0, 1);
		add_row(tbrc_pkg::FUNC_WRITE, SIZE_LONG, 32'h0000_0000, 32'h1234_5678,
			32'h0, 1, 32'h0, 0, 1);
		add_row(tbrc_pkg::FUNC_ENABLE, tbrc_pkg::SIZE_BYTE, 32'h0, 32'h0,
			32'h0, 1, 32'h0, 0, 0);
		// long fill that wraps around the top of the address space
		add_row(tbrc_pkg::FUNC_READ, SIZE_LONG, 32'hFFFF_FFFE, 32'h0,
			32'h1122_3344, 1, 32'h1122_3344, 0, 1);
		add_row(tbrc_pkg::FUNC_READ, SIZE_LONG, 32'hFFFF_FFFE, 32'h0,
			32'h0, 1, 32'h1122_3344, 1, 0);
		add_row(tbrc_pkg::FUNC_READ, tbrc_pkg::SIZE_WORD, 32'h0000_0000, 32'h0,
			32'h0, 1, 32'h0000_3344, 1, 0);
		add_row(tbrc_pkg::FUNC_WRITE, tbrc_pkg::SIZE_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFA5,
			32'h0, 1, 32'h0, 0, 1);
		add_row(tbrc_pkg::FUNC_READ, tbrc_pkg::SIZE_BYTE, 32'hFFFF_FFFF, 32'h0,
			32'h0, 0, 32'h0, 0, 0);
		// word write to absent bytes allocates nothing
		add_row(tbrc_pkg::FUNC_WRITE, tbrc_pkg::SIZE_WORD, 32'h0000_0100, 32'h0000_BEEF,
			32'h0, 1, 32'h0, 0, 1);
		add_row(tbrc_pkg::FUNC_READ, tbrc_pkg::SIZE_WORD, 32'h0000_0100, 32'h0,
			32'hFFFF_FFFF, 1, 32'h0000_FFFF, 0, 1);
		add_row(tbrc_pkg::FUNC_WRITE, SIZE_LONG, 32'h0000_0200, 32'hDEAD_BEEF,
			32'h0, 1, 32'h0, 0, 1);
		add_row(tbrc_pkg::FUNC_READ, SIZE_SPARE, 32'h0000_0200, 32'h0,
			32'h0, 0, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_READ, tbrc_pkg::SIZE_WORD, 32'h0000_01FF, 32'h0,
			32'h0000_5A5A, 0, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_INVALIDATE, SIZE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_READ, SIZE_LONG, 32'h0000_0200, 32'h0,
			32'h0, 1, 32'h0, 0, 1);
		add_row(tbrc_pkg::FUNC_ENABLE, tbrc_pkg::SIZE_WORD, 32'h0, 32'h0,
			32'h0, 1, 32'h0, 0, 0);
		// sixteen fills bring the replace pointer back to the slot of 0x403
		add_row(tbrc_pkg::FUNC_READ, tbrc_pkg::SIZE_BYTE, 32'h0000_0403, 32'h0,
			32'h0000_0077, 0, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_READ, SIZE_LONG, 32'h0000_0500, 32'h0,
			32'h0102_0304, 0, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_READ, SIZE_LONG, 32'h0000_0504, 32'h0,
			32'h0506_0708, 0, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_READ, SIZE_LONG, 32'h0000_0508, 32'h0,
			32'h090A_0B0C, 0, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_READ, tbrc_pkg::SIZE_WORD, 32'h0000_050C, 32'h0,
			32'h0000_0D0E, 0, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_READ, tbrc_pkg::SIZE_BYTE, 32'h0000_0510, 32'h0,
			32'h0000_000F, 0, 32'h0, 0, 0);
		// first byte of this fill evicts the last one, which is then filled again
		add_row(tbrc_pkg::FUNC_READ, SIZE_LONG, 32'h0000_0400, 32'h0,
			32'h9A9B_9C9D, 0, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_READ, SIZE_LONG, 32'h0000_0400, 32'h0,
			32'h0, 0, 32'h0, 0, 0);
		add_row(tbrc_pkg::FUNC_READ, tbrc_pkg::SIZE_BYTE, 32'h0000_0403, 32'h0,
			32'h0, 0, 32'h0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].want);
		wait_for_results();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 46 : 0;
			recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 33 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (i % 150 == 0)
					region_base = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 : $urandom;
				if (ph == 0 && i == RANDOM_PER_PHASE / 2)
					hold_off_req = 1'b1;
				if (ph == 1 && i == RANDOM_PER_PHASE / 2)
					wait_for_results();
				send_access(random_access(), 1'b0, '0);
			end
			wait_for_results();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words: %0d read hits, %0d read misses, %0d writes,",
			n_read_hit + n_read_miss + n_write + n_control, n_read_hit, n_read_miss,
			n_write);
		$display("%0d invalidate/enable; directed corner rows first, then random traffic",
			n_control);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
design/tbrc_pkg.sv
design/tbrc_lane.sv
design/tbrc_merge.sv
design/target_byte_read_cache_top.sv
sim/tb_target_byte_read_cache_top.sv
